// ----- sv/horner_polynomial_evaluator_macros.svh -----
// ----------------------------------------------------------------------------
// horner polynomial evaluator assertion macros
// shared property forms, clocked on clock and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH

// same-cycle implication
`define HPE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// next-cycle implication
`define HPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

// ----- sv/hpe_pkg.sv -----
// ----------------------------------------------------------------------------
// hpe_pkg
// widths, limits and stage control type for the horner polynomial evaluator
// ----------------------------------------------------------------------------
package hpe_pkg;

   localparam int ACC_W             = 32;
   localparam int PROD_W            = 2 * ACC_W;
   localparam int NUM_COEF_REGS     = 8;
   localparam int COEF_IDX_W        = $clog2(NUM_COEF_REGS);
   localparam int DEF_MAX_DEGREE    = 7;
   localparam int DEF_FRACTION_BITS = 16;

   typedef logic signed [ACC_W-1:0]  hpe_word_type;
   typedef logic signed [PROD_W-1:0] hpe_prod_type;

   localparam hpe_word_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam hpe_word_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic sat;
   } hpe_ctl_type;

endpackage

// ----- sv/horner_polynomial_evaluator.sv -----
// ----------------------------------------------------------------------------
// horner_polynomial_evaluator
// Evaluates coef_0 + coef_1*x + ... + coef_N*x^N (N = MAX_DEGREE) in signed
// fixed point with FRACTION_BITS fraction bits. A point is taken on any cycle
// with start high and busy low, so one point per cycle is sustained. The
// edge that takes a point loads it into the first stage, and the result
// passes through each further step's multiplier and add registers to the
// outputs. The first Horner step is the load stage, and each further
// step has one stage for the 32x32 multiplier and one for the scale, add
// and saturate. The result shows on rsp_poly_value and rsp_saturated for a
// single cycle with rsp_valid high; the receiver cannot stall, so results
// must be taken as they come. busy is high during reset and for the cycle
// that follows it. Coefficients are written through the csr port; the user
// must write them only while no point is in flight, since the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module horner_polynomial_evaluator #(
   parameter int MAX_DEGREE    = hpe_pkg::DEF_MAX_DEGREE,
   parameter int FRACTION_BITS = hpe_pkg::DEF_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [hpe_pkg::ACC_W-1:0] req_x_point,
   output logic                          rsp_valid,
   output logic signed [hpe_pkg::ACC_W-1:0] rsp_poly_value,
   output logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic [hpe_pkg::COEF_IDX_W-1:0] csr_index,
   input  logic [hpe_pkg::ACC_W-1:0]     csr_wdata
);
   import hpe_pkg::*;

   localparam logic [COEF_IDX_W-1:0] TOP_IDX = COEF_IDX_W'(MAX_DEGREE);

   hpe_word_type coef_ff [NUM_COEF_REGS];
   logic         busy_ff;

   hpe_ctl_type  st_ctl [MAX_DEGREE+1];
   hpe_word_type st_x   [MAX_DEGREE+1];
   hpe_word_type st_acc [MAX_DEGREE+1];
   hpe_ctl_type  mu_ctl [1:MAX_DEGREE];
   hpe_word_type mu_x   [1:MAX_DEGREE];
   hpe_prod_type mu_prod[1:MAX_DEGREE];

   hpe_ctl_type  load_ctl_ff;
   hpe_ctl_type  load_ctl_in;
   hpe_word_type load_x_ff;
   hpe_word_type load_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // first horner step from a zero accumulator is just the top coefficient
   always_comb begin
      load_ctl_in.valid = start & ~busy_ff;
      load_ctl_in.sat   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ctl_ff <= '0;
      end else begin
         load_ctl_ff <= load_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      load_x_ff   <= req_x_point;
      load_acc_ff <= coef_ff[TOP_IDX];
   end

   assign st_ctl[0]  = load_ctl_ff;
   assign st_x[0]    = load_x_ff;
   assign st_acc[0]  = load_acc_ff;

   for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_step
      localparam logic [COEF_IDX_W-1:0] CI = COEF_IDX_W'(MAX_DEGREE - k);

      hpe_mult u_mult (
         .clock     (clock),
         .reset     (reset),
         .stage_ctl (st_ctl[k-1]),
         .stage_x   (st_x[k-1]),
         .stage_acc (st_acc[k-1]),
         .mul_ctl   (mu_ctl[k]),
         .mul_x     (mu_x[k]),
         .mul_prod  (mu_prod[k])
      );

      hpe_sat_add #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_sat_add (
         .clock     (clock),
         .reset     (reset),
         .mul_ctl   (mu_ctl[k]),
         .mul_x     (mu_x[k]),
         .mul_prod  (mu_prod[k]),
         .coef      (coef_ff[CI]),
         .stage_ctl (st_ctl[k]),
         .stage_x   (st_x[k]),
         .stage_acc (st_acc[k])
      );
   end

   assign rsp_valid      = st_ctl[MAX_DEGREE].valid;
   assign rsp_poly_value = st_acc[MAX_DEGREE];
   assign rsp_saturated  = st_ctl[MAX_DEGREE].valid & st_ctl[MAX_DEGREE].sat;

endmodule

// ----- sv/hpe_mult.sv -----
// ----------------------------------------------------------------------------
// hpe_mult
// first half of a horner step: registered signed product of point and acc
// ----------------------------------------------------------------------------
module hpe_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  hpe_pkg::hpe_ctl_type stage_ctl,
   input  hpe_pkg::hpe_word_type stage_x,
   input  hpe_pkg::hpe_word_type stage_acc,
   output hpe_pkg::hpe_ctl_type mul_ctl,
   output hpe_pkg::hpe_word_type mul_x,
   output hpe_pkg::hpe_prod_type mul_prod
);
   import hpe_pkg::*;

   hpe_ctl_type  ctl_ff;
   hpe_word_type x_ff;
   hpe_prod_type prod_ff;
   hpe_prod_type prod_in;

   // both operands signed, so the full width product is exact
   assign prod_in = stage_x * stage_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= stage_ctl;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= stage_x;
      prod_ff <= prod_in;
   end

   assign mul_ctl  = ctl_ff;
   assign mul_x    = x_ff;
   assign mul_prod = prod_ff;

endmodule

// ----- sv/hpe_sat_add.sv -----
// ----------------------------------------------------------------------------
// hpe_sat_add
// second half of a horner step: scale the product, add the coefficient and
// clamp to the word range
// ----------------------------------------------------------------------------
module hpe_sat_add #(
   parameter int FRACTION_BITS = hpe_pkg::DEF_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hpe_pkg::hpe_ctl_type  mul_ctl,
   input  hpe_pkg::hpe_word_type mul_x,
   input  hpe_pkg::hpe_prod_type mul_prod,
   input  hpe_pkg::hpe_word_type coef,
   output hpe_pkg::hpe_ctl_type  stage_ctl,
   output hpe_pkg::hpe_word_type stage_x,
   output hpe_pkg::hpe_word_type stage_acc
);
   import hpe_pkg::*;

   hpe_ctl_type  ctl_ff;
   hpe_ctl_type  ctl_in;
   hpe_word_type x_ff;
   hpe_word_type acc_ff;
   hpe_word_type acc_in;
   hpe_prod_type scaled;
   hpe_prod_type sum;
   logic         pos_ovf;
   logic         neg_ovf;

   always_comb begin
      // arithmetic shift is a floor divide; the sum cannot wrap 64 bits
      scaled  = mul_prod >>> FRACTION_BITS;
      sum     = scaled + PROD_W'(coef);
      pos_ovf = !sum[PROD_W-1] && (|sum[PROD_W-2:ACC_W-1]);
      neg_ovf = sum[PROD_W-1] && !(&sum[PROD_W-2:ACC_W-1]);
      if (pos_ovf) begin
         acc_in = ACC_MAX;
      end else if (neg_ovf) begin
         acc_in = ACC_MIN;
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
      ctl_in.valid = mul_ctl.valid;
      ctl_in.sat   = mul_ctl.sat | pos_ovf | neg_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= mul_x;
      acc_ff <= acc_in;
   end

   assign stage_ctl = ctl_ff;
   assign stage_x   = x_ff;
   assign stage_acc = acc_ff;

endmodule

// ----- sv/hpe_checker.sv -----
// ----------------------------------------------------------------------------
// hpe_checker
// port level checks on the horner polynomial evaluator, bound to the top
// ----------------------------------------------------------------------------
`include "horner_polynomial_evaluator_macros.svh"

module hpe_checker #(
   parameter int MAX_DEGREE = hpe_pkg::DEF_MAX_DEGREE
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_saturated
);
   localparam int LATENCY = 2 * MAX_DEGREE + 1;

   // every item taken comes out after the fixed pipeline depth
   `HPE_ASSERT_IMPL(a_item_out, start && !busy, ##LATENCY rsp_valid, "item lost in pipeline")

   // no result without an item taken the pipeline depth earlier
   `HPE_ASSERT_IMPL(a_no_phantom, rsp_valid, $past(start && !busy, LATENCY), "result without item")

   // the flag is only shown alongside a result
   `HPE_ASSERT_IMPL(a_sat_qual, !rsp_valid, !rsp_saturated, "saturated flag without result")

   // busy only covers the cycle after reset
   `HPE_ASSERT_NEXT(a_busy_drop, !reset, !busy, "busy stuck high after reset")

endmodule

bind horner_polynomial_evaluator hpe_checker #(
   .MAX_DEGREE (MAX_DEGREE)
) u_hpe_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_saturated (rsp_saturated)
);

// ----- tb/horner_polynomial_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// horner_polynomial_evaluator_tb
// Streams signed Q16.16 points into the evaluator under several coefficient
// sets, predicts each value and saturation flag by Horner's rule in 64-bit
// arithmetic, and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module horner_polynomial_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hpe_pkg::*;

   localparam int MAX_DEGREE    = DEF_MAX_DEGREE;
   localparam int FRACTION_BITS = DEF_FRACTION_BITS;
   localparam int LATENCY       = 2 * MAX_DEGREE + 1;
   localparam int RANDOM_SETS   = 10;
   localparam int POINTS_PER_SET = 160;
   localparam int MAX_PRINTED   = 50;

   typedef struct {
      hpe_word_type value;
      logic         sat;
   } poly_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   hpe_word_type          req_x_point = '0;
   logic                  rsp_valid;
   hpe_word_type          rsp_poly_value;
   logic                  rsp_saturated;
   logic                  csr_we = 1'b0;
   logic [COEF_IDX_W-1:0] csr_index = '0;
   logic [ACC_W-1:0]      csr_wdata = '0;

   hpe_word_type    coef_model [NUM_COEF_REGS];
   hpe_word_type    coef_next [NUM_COEF_REGS];
   hpe_word_type    pending_points [$];
   poly_result_type predicted_values [$];
   poly_result_type oldest_value;

   int  burst_left = 0;
   int  gap_left = 0;
   bit  gapless = 1'b0;
   int  error_count = 0;
   int  points_sent = 0;
   int  results_seen = 0;
   int  sat_seen = 0;
   int  coef_sets = 0;

   horner_polynomial_evaluator #(
      .MAX_DEGREE    (MAX_DEGREE),
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_point    (req_x_point),
      .rsp_valid      (rsp_valid),
      .rsp_poly_value (rsp_poly_value),
      .rsp_saturated  (rsp_saturated),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // horner's rule, top coefficient down, each step sum clamped to 32 bits
   function automatic poly_result_type horner_eval(hpe_word_type x);
      poly_result_type r;
      longint          acc;
      longint          step_sum;
      r.sat = 1'b0;
      acc   = 0;
      for (int i = MAX_DEGREE; i >= 0; i--) begin
         step_sum = longint'(coef_model[i]) + ((longint'(x) * acc) >>> FRACTION_BITS);
         if (step_sum > longint'(ACC_MAX)) begin
            step_sum = longint'(ACC_MAX);
            r.sat    = 1'b1;
         end else if (step_sum < longint'(ACC_MIN)) begin
            step_sum = longint'(ACC_MIN);
            r.sat    = 1'b1;
         end
         acc = step_sum;
      end
      r.value = hpe_word_type'(acc);
      return r;
   endfunction

   function automatic hpe_word_type random_point();
      hpe_word_type v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3, 4, 5, 6: v = int'($urandom_range(0, 262144)) - 131072;
         7: v = ($urandom_range(0, 1) ? 32'sh0001_0000 : 32'shFFFF_0000)
                + int'($urandom_range(0, 511)) - 256;
         8: begin
            case ($urandom_range(0, 4))
               0:       v = ACC_MAX;
               1:       v = ACC_MIN;
               2:       v = '0;
               3:       v = '1;
               default: v = 32'sh0000_8000;
            endcase
         end
         default: v = hpe_word_type'($urandom) >>> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   function automatic hpe_word_type random_coef(int kind);
      hpe_word_type v;
      case (kind)
         0: v = int'($urandom_range(0, 524288)) - 262144;
         1: v = $urandom;
         2: v = ($urandom_range(0, 2) == 0) ? '0 : int'($urandom_range(0, 524288)) - 262144;
         3: v = hpe_word_type'($urandom) >>> $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 3))
               0:       v = ACC_MAX;
               1:       v = ACC_MIN;
               2:       v = '0;
               default: v = 32'sh0001_0000;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // append one point to the tail of the pending items
   task automatic queue_point(input hpe_word_type x);
      pending_points = {pending_points, x};
   endtask

   task automatic load_coefs();
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
         @(posedge clock);
         csr_we        <= 1'b1;
         csr_index     <= COEF_IDX_W'(i);
         csr_wdata     <= coef_next[i];
         coef_model[i] = coef_next[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      coef_sets++;
      @(negedge clock);
   endtask

   // all items taken and every result back, then let the pipe empty
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_points.size() != 0 || start || predicted_values.size() != 0);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // driver: presents the head of pending_points in bursts with gaps
   always @(posedge clock) begin
      if (reset) begin
         start       <= 1'b0;
         req_x_point <= '0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (start && !busy) begin
            predicted_values = {predicted_values, horner_eval(req_x_point)};
            void'(pending_points.pop_front());
            points_sent++;
         end
         if (start && busy) begin
            // item held until taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_points.size() > 0) begin
            start       <= 1'b1;
            req_x_point <= pending_points[0];
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 31);
               gap_left   = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results cannot be held off, so every strobe is checked at once
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (predicted_values.size() == 0) begin
            report_mismatch($sformatf("result %h with no item awaiting it", rsp_poly_value));
         end else begin
            oldest_value = predicted_values.pop_front();
            results_seen++;
            if (oldest_value.sat)
               sat_seen++;
            if (rsp_poly_value !== oldest_value.value)
               report_mismatch($sformatf("poly_value %h, predicted %h",
                                         rsp_poly_value, oldest_value.value));
            if (rsp_saturated !== oldest_value.sat)
               report_mismatch($sformatf("saturated %b, predicted %b (value %h)",
                                         rsp_saturated, oldest_value.sat, oldest_value.value));
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_model[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // coefficients straight out of reset
      @(negedge clock);
      queue_point(32'sh0000_0000);
      queue_point(32'sh7FFF_FFFF);
      wait_idle();

      // alternating integer coefficients against the edges of the point range
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_next[i] = (i % 2) ? -((i + 1) <<< FRACTION_BITS) : ((i + 1) <<< FRACTION_BITS);
      load_coefs();
      queue_point(32'sh0000_0000);
      queue_point(32'sh0001_0000);
      queue_point(32'shFFFF_0000);
      queue_point(32'sh0000_8000);
      queue_point(32'shFFFF_FFFF);
      queue_point(32'sh0000_0001);
      queue_point(32'sh7FFF_FFFF);
      queue_point(32'sh8000_0000);
      queue_point(32'sh0002_0000);
      queue_point(32'shFFFF_8000);
      wait_idle();

      // every coefficient at the positive limit, then at the negative limit
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_next[i] = ACC_MAX;
      load_coefs();
      queue_point(32'sh0000_0000);
      queue_point(32'sh0001_0000);
      queue_point(32'shFFFF_0000);
      queue_point(32'sh8000_0000);
      wait_idle();
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_next[i] = ACC_MIN;
      load_coefs();
      queue_point(32'sh0000_0000);
      queue_point(32'sh0001_0000);
      queue_point(32'shFFFF_0000);
      queue_point(32'sh7FFF_FFFF);
      wait_idle();

      // saturation in the step for coefficient 1, value back in range at the end, flag kept
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_next[i] = '0;
      coef_next[2] = ACC_MAX;
      coef_next[1] = ACC_MAX;
      load_coefs();
      queue_point(32'sh0000_8000);
      queue_point(32'shFFFF_8000);
      queue_point(32'sh0001_0000);
      wait_idle();

      for (int s = 0; s < RANDOM_SETS; s++) begin
         for (int i = 0; i < NUM_COEF_REGS; i++)
            coef_next[i] = random_coef(s % 5);
         gapless = (s == 3);
         load_coefs();
         for (int n = 0; n < POINTS_PER_SET; n++)
            queue_point(random_point());
         wait_idle();
      end

      $display("%0d points under %0d coefficient sets, %0d results checked",
               points_sent, coef_sets, results_seen);
      $display("%0d of those results saturated on some step", sat_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("run stopped by timeout with %0d results awaited", predicted_values.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
